[rtl/core/aadq_pkg.sv]
// Shared types and constants of the analog alarm delay qualifier.
`default_nettype none

package aadq_pkg;

  // Default width of the time base and of the start stamps.
  localparam int DEFAULT_TIME_WIDTH = 32;

  // Event codes carried by each result.
  typedef enum logic [1:0] {
    EV_NONE          = 2'd0,
    EV_HIGH_RAISED   = 2'd1,
    EV_LOW_RAISED    = 2'd2,
    EV_BACK_IN_RANGE = 2'd3
  } event_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_HIGH_LIMIT     = 3'd0,
    CFG_LOW_LIMIT      = 3'd1,
    CFG_HIGH_ON_DELAY  = 3'd2,
    CFG_HIGH_OFF_DELAY = 3'd3,
    CFG_LOW_ON_DELAY   = 3'd4,
    CFG_LOW_OFF_DELAY  = 3'd5,
    CFG_LIMIT_ENABLES  = 3'd6
  } cfg_index_t;

  // Per-limit settings handed to one qualifier.
  typedef struct packed {
    logic        enable;
    logic [15:0] on_delay;
    logic [15:0] off_delay;
  } limit_cfg_t;

endpackage

`default_nettype wire

[rtl/core/aadq_judge.sv]
// Alarm condition for one limit: on-delay qualification and off-delay hold.
`default_nettype none

module aadq_judge #(
  parameter int TIME_WIDTH = aadq_pkg::DEFAULT_TIME_WIDTH
) (
  input  aadq_pkg::limit_cfg_t  cfg,
  input  logic                  beyond,
  input  logic                  flag,
  input  logic [TIME_WIDTH-1:0] now,
  input  logic [TIME_WIDTH-1:0] on_start,
  input  logic [TIME_WIDTH-1:0] off_start,
  output logic                  alarm
);
  import aadq_pkg::*;

  logic [TIME_WIDTH-1:0] on_elapsed;
  logic [TIME_WIDTH-1:0] off_elapsed;
  logic                  on_ok;
  logic                  hold;

  // Elapsed times wrap with the time base.
  assign on_elapsed  = now - on_start;
  assign off_elapsed = now - off_start;

  // The value has been beyond the limit long enough, or no delay is set.
  assign on_ok = beyond &&
                 ((cfg.on_delay == 16'd0) ||
                  ((on_start != '0) && (on_elapsed >= TIME_WIDTH'(cfg.on_delay))));

  // An active alarm is held while its off-delay has not run out.
  assign hold = !beyond && flag && (cfg.off_delay != 16'd0) &&
                ((off_start == '0) || (off_elapsed < TIME_WIDTH'(cfg.off_delay)));

  assign alarm = cfg.enable && (on_ok || hold);

endmodule

`default_nettype wire

[rtl/core/analog_alarm_delay_qualifier_top.sv]
// Top level of the analog high/low limit alarm with on-delay and off-delay.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------
//   in_     | input     | in_valid / in_ready  | eng_value, sample_ok, now_seconds
//   out_    | output    | out_valid / out_ready| event_code, high/low_active, sample_valid
//   cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each request passes an input register and a result register. One request is
// taken every cycle unless a stalled result keeps the input register full.
// The alarm state is updated as a request moves from the input register into
// the result register. A stalled result holds both stages; the input side
// keeps accepting while the input register is free. cfg_ready is always high.
// Reset clears the configuration, the alarm flags, the stamps and both stages.
`default_nettype none

module analog_alarm_delay_qualifier_top #(
  parameter int TIME_WIDTH = aadq_pkg::DEFAULT_TIME_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_eng_value,
  input  logic               in_sample_ok,
  input  logic        [31:0] in_now_seconds,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [1:0]  out_event_code,
  output logic               out_high_active,
  output logic               out_low_active,
  output logic               out_sample_valid,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [31:0] cfg_data
);
  import aadq_pkg::*;

  // Configuration registers.
  logic signed [31:0] high_limit_r;
  logic signed [31:0] low_limit_r;
  logic        [15:0] high_on_delay_r;
  logic        [15:0] high_off_delay_r;
  logic        [15:0] low_on_delay_r;
  logic        [15:0] low_off_delay_r;
  logic        [1:0]  limit_enables_r;

  // Input register.
  logic               s1_valid_r;
  logic signed [31:0] s1_value_r;
  logic               s1_ok_r;
  logic        [31:0] s1_now_r;

  // Alarm state.
  logic                  high_flag_r, high_flag_nxt;
  logic                  low_flag_r, low_flag_nxt;
  logic [TIME_WIDTH-1:0] high_on_start_r, high_on_start_nxt;
  logic [TIME_WIDTH-1:0] high_off_start_r, high_off_start_nxt;
  logic [TIME_WIDTH-1:0] low_on_start_r, low_on_start_nxt;
  logic [TIME_WIDTH-1:0] low_off_start_r, low_off_start_nxt;

  // Result register.
  logic   out_valid_r;
  event_t event_r, event_nxt;
  logic   out_high_r;
  logic   out_low_r;
  logic   out_ok_r;

  logic                  advance;
  logic [63:0]           now_wide;
  logic [TIME_WIDTH-1:0] now;
  logic                  value_high;
  logic                  value_low;
  logic                  alarm_high;
  logic                  alarm_low;
  limit_cfg_t            high_cfg;
  limit_cfg_t            low_cfg;

  // The pipeline moves whenever the result register is free or being taken.
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  // Configuration writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_limit_r     <= '0;
      low_limit_r      <= '0;
      high_on_delay_r  <= '0;
      high_off_delay_r <= '0;
      low_on_delay_r   <= '0;
      low_off_delay_r  <= '0;
      limit_enables_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HIGH_LIMIT:     high_limit_r     <= cfg_data;
        CFG_LOW_LIMIT:      low_limit_r      <= cfg_data;
        CFG_HIGH_ON_DELAY:  high_on_delay_r  <= cfg_data[15:0];
        CFG_HIGH_OFF_DELAY: high_off_delay_r <= cfg_data[15:0];
        CFG_LOW_ON_DELAY:   low_on_delay_r   <= cfg_data[15:0];
        CFG_LOW_OFF_DELAY:  low_off_delay_r  <= cfg_data[15:0];
        CFG_LIMIT_ENABLES:  limit_enables_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_value_r <= in_eng_value;
      s1_ok_r    <= in_sample_ok;
      s1_now_r   <= in_now_seconds;
    end
  end

  // Time base, zero-extended or truncated to the stamp width.
  assign now_wide = {32'd0, s1_now_r};
  assign now      = now_wide[TIME_WIDTH-1:0];

  // Limit compares.
  assign value_high = s1_value_r > high_limit_r;
  assign value_low  = s1_value_r < low_limit_r;

  assign high_cfg = '{enable: limit_enables_r[0], on_delay: high_on_delay_r,
                      off_delay: high_off_delay_r};
  assign low_cfg  = '{enable: limit_enables_r[1], on_delay: low_on_delay_r,
                      off_delay: low_off_delay_r};

  aadq_judge #(.TIME_WIDTH(TIME_WIDTH)) u_judge_high (
    .cfg       (high_cfg),
    .beyond    (value_high),
    .flag      (high_flag_r),
    .now       (now),
    .on_start  (high_on_start_r),
    .off_start (high_off_start_r),
    .alarm     (alarm_high)
  );

  aadq_judge #(.TIME_WIDTH(TIME_WIDTH)) u_judge_low (
    .cfg       (low_cfg),
    .beyond    (value_low),
    .flag      (low_flag_r),
    .now       (now),
    .on_start  (low_on_start_r),
    .off_start (low_off_start_r),
    .alarm     (alarm_low)
  );

  // Alarm state update; the high alarm wins over the low alarm.
  always_comb begin
    high_flag_nxt      = high_flag_r;
    low_flag_nxt       = low_flag_r;
    high_on_start_nxt  = high_on_start_r;
    high_off_start_nxt = high_off_start_r;
    low_on_start_nxt   = low_on_start_r;
    low_off_start_nxt  = low_off_start_r;
    event_nxt          = EV_NONE;
    if (s1_ok_r) begin
      priority if (alarm_high) begin
        if (!high_flag_r) begin
          high_flag_nxt = 1'b1;
          low_flag_nxt  = 1'b0;
          event_nxt     = EV_HIGH_RAISED;
        end
        if (value_high) begin
          high_off_start_nxt = '0;
          low_off_start_nxt  = '0;
          low_on_start_nxt   = '0;
        end else begin
          if (high_off_start_r == '0) begin
            high_off_start_nxt = now;
          end
          low_off_start_nxt = '0;
          low_on_start_nxt  = value_low ? now : '0;
        end
      end else if (alarm_low) begin
        if (!low_flag_r) begin
          low_flag_nxt  = 1'b1;
          high_flag_nxt = 1'b0;
          event_nxt     = EV_LOW_RAISED;
        end
        if (value_low) begin
          high_off_start_nxt = '0;
          low_off_start_nxt  = '0;
          high_on_start_nxt  = '0;
        end else begin
          if (low_off_start_r == '0) begin
            low_off_start_nxt = now;
          end
          high_off_start_nxt = '0;
          high_on_start_nxt  = value_high ? now : '0;
        end
      end else begin
        // Alarms drop; the event is reported only once the value is in range.
        if (high_flag_r || low_flag_r) begin
          high_flag_nxt = 1'b0;
          low_flag_nxt  = 1'b0;
          if (!value_high && !value_low) begin
            event_nxt = EV_BACK_IN_RANGE;
          end
        end
        priority if (value_high) begin
          low_on_start_nxt = '0;
          if (high_on_start_r == '0) begin
            high_on_start_nxt = now;
          end
        end else if (value_low) begin
          high_on_start_nxt = '0;
          if (low_on_start_r == '0) begin
            low_on_start_nxt = now;
          end
        end else begin
          high_on_start_nxt = '0;
          low_on_start_nxt  = '0;
        end
      end
    end
  end

  // State registers advance with each request leaving the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_flag_r      <= 1'b0;
      low_flag_r       <= 1'b0;
      high_on_start_r  <= '0;
      high_off_start_r <= '0;
      low_on_start_r   <= '0;
      low_off_start_r  <= '0;
    end else if (advance && s1_valid_r) begin
      high_flag_r      <= high_flag_nxt;
      low_flag_r       <= low_flag_nxt;
      high_on_start_r  <= high_on_start_nxt;
      high_off_start_r <= high_off_start_nxt;
      low_on_start_r   <= low_on_start_nxt;
      low_off_start_r  <= low_off_start_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      event_r    <= event_nxt;
      out_high_r <= high_flag_nxt;
      out_low_r  <= low_flag_nxt;
      out_ok_r   <= s1_ok_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_code   = event_r;
  assign out_high_active  = out_high_r;
  assign out_low_active   = out_low_r;
  assign out_sample_valid = out_ok_r;

endmodule

`default_nettype wire

[rtl/core/aadq_checker.sv]
// Port-level checks of the alarm qualifier and their binding to the top level.
`default_nettype none

module aadq_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_event_code,
  input  logic        out_high_active,
  input  logic        out_low_active,
  input  logic        out_sample_valid
);
  import aadq_pkg::*;

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_code) &&
    $stable(out_high_active) && $stable(out_low_active) && $stable(out_sample_valid))
    else $error("stalled result changed");

  // The two alarm flags are never active together.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_high_active && out_low_active))
    else $error("high and low alarm active together");

  // An invalid sample never reports an event.
  a_invalid_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sample_valid |-> out_event_code == EV_NONE)
    else $error("event on invalid sample");

  // Each event agrees with the flags it reports.
  a_event_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_event_code == EV_NONE) ||
       ((out_event_code == EV_HIGH_RAISED) && out_high_active && !out_low_active) ||
       ((out_event_code == EV_LOW_RAISED) && out_low_active && !out_high_active) ||
       ((out_event_code == EV_BACK_IN_RANGE) && !out_high_active && !out_low_active)))
    else $error("event disagrees with alarm flags");

  // Reset empties the result side.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind analog_alarm_delay_qualifier_top aadq_checker u_aadq_checker (.*);

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the analog high/low limit alarm with on-delay and off-delay.
`timescale 1ns / 1ps

module tb;
  import aadq_pkg::*;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [2:0] CFG_INDEX_UNUSED = 3'd7;
  // Reference thresholds of +/-100.0 in Q16.16, and 1.0 in Q16.16.
  localparam logic signed [31:0] HI_REF = 32'sd6553600;
  localparam logic signed [31:0] LO_REF = -32'sd6553600;
  localparam logic signed [31:0] Q_ONE  = 32'sd65536;
  // Cycles without any handshake before the run is abandoned.
  localparam int QUIET_LIMIT = 1000;
  // Cycles allowed after the last result for anything stray to show up.
  localparam int SETTLE_CYCLES = 4;
  // Most diagnostic lines printed.
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    event_t code;
    logic   high;
    logic   low;
    logic   valid;
  } alarm_result_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_eng_value;
  logic               in_sample_ok;
  logic        [31:0] in_now_seconds;
  logic               out_valid;
  logic               out_ready;
  logic        [1:0]  out_event_code;
  logic               out_high_active;
  logic               out_low_active;
  logic               out_sample_valid;
  logic               cfg_valid;
  logic               cfg_ready;
  logic        [2:0]  cfg_index;
  logic        [31:0] cfg_data;

  // Settings and alarm state as the block should hold them.
  logic signed [31:0] lim_high = '0;
  logic signed [31:0] lim_low = '0;
  logic [15:0] dly_hi_on = '0;
  logic [15:0] dly_hi_off = '0;
  logic [15:0] dly_lo_on = '0;
  logic [15:0] dly_lo_off = '0;
  logic [1:0]  lim_en = '0;
  logic        hi_flag = 1'b0;
  logic        lo_flag = 1'b0;
  logic [31:0] hi_on_ts = '0;
  logic [31:0] hi_off_ts = '0;
  logic [31:0] lo_on_ts = '0;
  logic [31:0] lo_off_ts = '0;

  alarm_result_t expected_alarms[$];
  int err_count = 0;
  int quiet_cycles = 0;
  int in_gap_max = 0;
  int out_gap_max = 0;

  analog_alarm_delay_qualifier_top DUT (.*);

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abandon the run if no request moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_PRINTS) begin
      $display("ERROR at %0t ns: %s", $time, what);
    end
  endtask

  // Decides whether one limit's alarm condition holds for this sample.
  function automatic logic limit_qualifies(input logic en, input logic beyond, input logic flag,
                                           input logic [31:0] now, input logic [15:0] on_d,
                                           input logic [31:0] on_s, input logic [15:0] off_d,
                                           input logic [31:0] off_s);
    logic [31:0] on_el;
    logic [31:0] off_el;
    logic on_ok;
    logic hold;
    on_el = now - on_s;
    off_el = now - off_s;
    on_ok = beyond && (on_d == 0 || (on_s != 0 && on_el >= on_d));
    hold = !beyond && flag && off_d != 0 && (off_s == 0 || off_el < off_d);
    return en && (on_ok || hold);
  endfunction

  // Moves the alarm state on by one sample and returns the result it should give.
  function automatic alarm_result_t advance_alarm(input logic signed [31:0] v, input logic ok,
                                                  input logic [31:0] now);
    alarm_result_t r;
    logic vh;
    logic vl;
    logic ah;
    logic al;
    r.code = EV_NONE;
    if (ok) begin
      vh = v > lim_high;
      vl = v < lim_low;
      ah = limit_qualifies(lim_en[0], vh, hi_flag, now, dly_hi_on, hi_on_ts, dly_hi_off,
                           hi_off_ts);
      al = limit_qualifies(lim_en[1], vl, lo_flag, now, dly_lo_on, lo_on_ts, dly_lo_off,
                           lo_off_ts);
      if (ah) begin
        if (!hi_flag) begin
          hi_flag = 1'b1;
          lo_flag = 1'b0;
          r.code = EV_HIGH_RAISED;
        end
        if (vh) begin
          hi_off_ts = '0;
          lo_off_ts = '0;
          lo_on_ts = '0;
        end else begin
          // High alarm held through its off-delay; a low value restarts the low timer.
          if (hi_off_ts == 0) hi_off_ts = now;
          lo_off_ts = '0;
          lo_on_ts = vl ? now : 32'd0;
        end
      end else if (al) begin
        if (!lo_flag) begin
          lo_flag = 1'b1;
          hi_flag = 1'b0;
          r.code = EV_LOW_RAISED;
        end
        if (vl) begin
          hi_off_ts = '0;
          lo_off_ts = '0;
          hi_on_ts = '0;
        end else begin
          if (lo_off_ts == 0) lo_off_ts = now;
          hi_off_ts = '0;
          hi_on_ts = vh ? now : 32'd0;
        end
      end else begin
        // Flags clear, but the event is only given once the value is truly in range.
        if (hi_flag || lo_flag) begin
          hi_flag = 1'b0;
          lo_flag = 1'b0;
          if (!vh && !vl) r.code = EV_BACK_IN_RANGE;
        end
        if (vh) begin
          lo_on_ts = '0;
          if (hi_on_ts == 0) hi_on_ts = now;
        end else if (vl) begin
          hi_on_ts = '0;
          if (lo_on_ts == 0) lo_on_ts = now;
        end else begin
          hi_on_ts = '0;
          lo_on_ts = '0;
        end
      end
    end
    r.high = hi_flag;
    r.low = lo_flag;
    r.valid = ok;
    return r;
  endfunction

  // Writes one register and mirrors it into the expected settings.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_HIGH_LIMIT:     lim_high = data;
      CFG_LOW_LIMIT:      lim_low = data;
      CFG_HIGH_ON_DELAY:  dly_hi_on = data[15:0];
      CFG_HIGH_OFF_DELAY: dly_hi_off = data[15:0];
      CFG_LOW_ON_DELAY:   dly_lo_on = data[15:0];
      CFG_LOW_OFF_DELAY:  dly_lo_off = data[15:0];
      CFG_LIMIT_ENABLES:  lim_en = data[1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] hl, input logic [31:0] ll,
                                input logic [31:0] hon, input logic [31:0] hoff,
                                input logic [31:0] lon, input logic [31:0] loff,
                                input logic [31:0] en);
    write_reg(CFG_HIGH_LIMIT, hl);
    write_reg(CFG_LOW_LIMIT, ll);
    write_reg(CFG_HIGH_ON_DELAY, hon);
    write_reg(CFG_HIGH_OFF_DELAY, hoff);
    write_reg(CFG_LOW_ON_DELAY, lon);
    write_reg(CFG_LOW_OFF_DELAY, loff);
    write_reg(CFG_LIMIT_ENABLES, en);
  endtask

  // Sends one sample request after a random pause and records its expected result.
  task automatic send_sample(input logic signed [31:0] v, input logic ok,
                             input logic [31:0] now);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_eng_value <= v;
    in_sample_ok <= ok;
    in_now_seconds <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_alarms.push_back(advance_alarm(v, ok, now));
  endtask

  // Lets every outstanding result arrive, then a few quiet cycles.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_alarms.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: random back-pressure, then compare each result with the oldest expectation.
  initial begin
    alarm_result_t want;
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = $urandom_range(0, out_gap_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (expected_alarms.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = expected_alarms.pop_front();
        if (out_event_code !== want.code)
          report_mismatch($sformatf("event_code %0d, expected %0d", out_event_code, want.code));
        if (out_high_active !== want.high)
          report_mismatch($sformatf("high_active %b, expected %b", out_high_active, want.high));
        if (out_low_active !== want.low)
          report_mismatch($sformatf("low_active %b, expected %b", out_low_active, want.low));
        if (out_sample_valid !== want.valid)
          report_mismatch($sformatf("sample_valid %b, expected %b", out_sample_valid,
                                    want.valid));
      end
    end
  end

  // With the reset settings both alarms are disabled, whatever the value.
  task automatic test_reset_state();
    send_sample(32'sh7FFFFFFF, 1'b1, 32'd1);
    send_sample(32'sh80000000, 1'b1, 32'd2);
    send_sample(32'sh80000000, 1'b0, 32'd3);
    wait_for_results();
  endtask

  // Zero delays: alarms follow the value at once; invalid samples leave the state alone.
  task automatic test_immediate_alarms();
    apply_settings(HI_REF, LO_REF, 0, 0, 0, 0, 3);
    send_sample(32'sh7FFFFFFF, 1'b1, 32'd10);
    send_sample(32'sh80000000, 1'b1, 32'd11);
    send_sample(32'sh80000000, 1'b0, 32'd12);
    send_sample(32'sd0, 1'b1, 32'd13);
    send_sample(HI_REF + 1, 1'b1, 32'd0);
    wait_for_results();
  endtask

  // On- and off-delays, a stamp taken at time zero, and the seconds counter wrapping.
  task automatic test_delays();
    apply_settings(HI_REF, LO_REF, 3, 2, 2, 4, 3);
    send_sample(HI_REF + 1, 1'b1, 32'd0);
    send_sample(HI_REF + 1, 1'b1, 32'd1);
    send_sample(HI_REF + 1, 1'b1, 32'd3);
    send_sample(HI_REF + 1, 1'b1, 32'd4);
    send_sample(32'sd0, 1'b1, 32'd5);
    send_sample(LO_REF - 1, 1'b1, 32'd6);
    send_sample(32'sd0, 1'b1, 32'd7);
    send_sample(HI_REF + 1, 1'b1, 32'hFFFF_FFFE);
    send_sample(HI_REF + 1, 1'b1, 32'd1);
    send_sample(HI_REF, 1'b1, 32'd2);
    wait_for_results();
  endtask

  // High limit below the low limit, so a value can be in both regions.
  task automatic test_overlapping_limits();
    apply_settings(-Q_ONE, Q_ONE, 0, 0, 0, 0, 3);
    send_sample(32'sd0, 1'b1, 32'd20);
    send_sample(32'sd0, 1'b1, 32'd21);
    wait_for_results();
    write_reg(CFG_LIMIT_ENABLES, 2);
    send_sample(32'sd0, 1'b1, 32'd22);
    wait_for_results();
  endtask

  // Disabling a limit whose alarm is active clears it without a back-in-range event.
  task automatic test_disabled_limit();
    apply_settings(HI_REF, LO_REF, 0, 0, 0, 5, 3);
    send_sample(LO_REF - 1, 1'b1, 32'd30);
    wait_for_results();
    write_reg(CFG_LIMIT_ENABLES, 1);
    send_sample(LO_REF - 1, 1'b1, 32'd31);
    send_sample(32'sd0, 1'b1, 32'd32);
    wait_for_results();
  endtask

  // A write to an unused index must leave every setting as it was.
  task automatic test_unused_index();
    write_reg(CFG_INDEX_UNUSED, 32'hFFFF_FFFF);
    send_sample(HI_REF + 1, 1'b1, 32'd40);
    send_sample(LO_REF - 1, 1'b1, 32'd41);
    wait_for_results();
  endtask

  // Delay setting for a random phase, with junk in the bits above the register.
  function automatic logic [31:0] pick_delay();
    logic [15:0] d;
    case ($urandom_range(0, 9))
      0: d = 16'd0;
      1: d = 16'hFFFF;
      2: d = 16'($urandom);
      default: d = 16'($urandom_range(1, 4));
    endcase
    return {16'($urandom), d};
  endfunction

  // Random phases: each with its own settings, samples dwelling near the limits.
  task automatic test_random_phases();
    logic signed [31:0] hl;
    logic signed [31:0] ll;
    logic signed [31:0] v;
    logic [31:0] t;
    logic [1:0] en;
    int region;
    for (int p = 0; p < 15; p++) begin
      case ($urandom_range(0, 6))
        0: begin hl = 32'sh7FFFFFFF; ll = 32'sh80000000; end
        1: begin hl = 32'sh80000000; ll = 32'sh7FFFFFFF; end
        2: begin hl = -int'($urandom_range(0, 5000)); ll = int'($urandom_range(0, 5000)); end
        3: begin hl = $urandom; ll = $urandom; end
        default: begin
          hl = int'($urandom_range(0, 100000));
          ll = -int'($urandom_range(0, 100000));
        end
      endcase
      en = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 2)) : 2'd3;
      apply_settings(hl, ll, pick_delay(), pick_delay(), pick_delay(), pick_delay(),
                     {30'($urandom), en});
      if ($urandom_range(0, 2) == 0) write_reg(CFG_INDEX_UNUSED, $urandom);
      in_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
      out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
      t = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFF8 : $urandom;
      region = 2;
      for (int i = 0; i < 102; i++) begin
        // The value stays in one region for a few samples so that delays can run out.
        if ($urandom_range(0, 3) == 0) region = $urandom_range(0, 4);
        case (region)
          0: v = lim_high + int'($urandom_range(1, 50));
          1: v = lim_low - int'($urandom_range(1, 50));
          2: v = (lim_high >>> 1) + (lim_low >>> 1);
          3: v = $urandom_range(0, 1) ? lim_high : lim_low;
          default: v = $urandom;
        endcase
        case ($urandom_range(0, 29))
          0: t = $urandom;
          1: t = 32'd0;
          2: t = t + 32'd65535 + $urandom_range(0, 2);
          default: t = t + $urandom_range(0, 2);
        endcase
        send_sample(v, $urandom_range(0, 9) != 0, t);
      end
      wait_for_results();
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_eng_value <= '0;
    in_sample_ok <= 1'b0;
    in_now_seconds <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_gap_max = 5;
    out_gap_max = 5;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_immediate_alarms();
    test_delays();
    test_overlapping_limits();
    test_disabled_limit();
    test_unused_index();
    test_random_phases();
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
